// File: rtl/hash_table_linear_probe_macros.svh
// Assertion macros shared by the hash table RTL.
`ifndef HASH_TABLE_LINEAR_PROBE_MACROS_SVH
`define HASH_TABLE_LINEAR_PROBE_MACROS_SVH

// Check on every rising edge of clk, quiet while rst is high.
`define HTLP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge of clk, reset included.
`define HTLP_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/htlp_pkg.sv
// Shared constants, codes and word types of the hash table.
package htlp_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 9;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [OCC_W-1:0] occ_t;

  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_UPDATED   = 3'd2;
  localparam logic [2:0] ST_INSERTED  = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [63:0] MIX_C0 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] read_value;
    occ_t             occupancy;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

// File: rtl/htlp_hash.sv
// Five-stage splitmix64 pipeline that yields the home slot of a key.
module htlp_hash (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [63:0]             key,
  output logic                    out_valid,
  output htlp_pkg::idx_t          home
);

  logic [4:0]  vld;
  logic [63:0] s1_x;
  logic [63:0] s2_ll;
  logic [31:0] s2_lh;
  logic [31:0] s2_hl;
  logic [63:0] s3_x;
  logic [63:0] s4_ll;
  logic [31:0] s4_lh;
  logic [31:0] s4_hl;
  logic [63:0] add0;
  logic [63:0] prod1;
  logic [63:0] mix1;
  logic [63:0] prod2;
  logic [63:0] mix2;

  assign add0  = key + htlp_pkg::MIX_C0;
  assign prod1 = s2_ll + {s2_lh + s2_hl, 32'b0};
  assign mix1  = prod1 ^ (prod1 >> 27);
  assign prod2 = s4_ll + {s4_lh + s4_hl, 32'b0};
  assign mix2  = prod2 ^ (prod2 >> 31);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
    // 64x64 low product split into one full and two cross 32x32 products
    s1_x  <= add0 ^ (add0 >> 30);
    s2_ll <= s1_x[31:0] * htlp_pkg::MIX_C1[31:0];
    s2_lh <= 32'(s1_x[31:0] * htlp_pkg::MIX_C1[63:32]);
    s2_hl <= 32'(s1_x[63:32] * htlp_pkg::MIX_C1[31:0]);
    s3_x  <= mix1;
    s4_ll <= s3_x[31:0] * htlp_pkg::MIX_C2[31:0];
    s4_lh <= 32'(s3_x[31:0] * htlp_pkg::MIX_C2[63:32]);
    s4_hl <= 32'(s3_x[63:32] * htlp_pkg::MIX_C2[31:0]);
    home  <= mix2[htlp_pkg::IDX_W-1:0];
  end

  assign out_valid = vld[4];

endmodule

// File: rtl/htlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hash_table_linear_probe.sv
// Top level of the open-addressing hash table with linear probing.
// Open-addressing hash table of CAPACITY (256) slots, each holding a 64-bit
// key, a 64-bit value and a mark (empty, live, tombstone). Raise start with a
// command word on cmd while busy is low; the word is taken at that edge. The
// result word appears on result for exactly one cycle with done high and
// must be taken then: there is no way to hold it. After reset the block runs
// a clearing pass that marks every slot empty, with busy high throughout.
// A command then passes through the splitmix64 pipeline, one slot-memory read
// fetches the home slot, and the walk then reads one slot per cycle through
// the single read port of the slot memory, up to CAPACITY slots (a single slot
// for a hit or empty home slot). busy falls with done, so the next command can
// be taken in the cycle that done is shown. Writes (insert, update, tombstone)
// land at the end of the walk, long before the next command's first read, so
// no forwarding is needed.
`include "hash_table_linear_probe_macros.svh"

module hash_table_linear_probe (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  htlp_pkg::cmd_t      cmd,
  output logic                done,
  output htlp_pkg::rsp_t      result
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE
  } state_t;

  state_t               state;
  htlp_pkg::idx_t       clr_idx;
  htlp_pkg::cmd_t       cmd_q;
  htlp_pkg::idx_t       cur_idx;
  htlp_pkg::idx_t       step;
  htlp_pkg::idx_t       tomb_idx;
  logic                 have_tomb;
  htlp_pkg::cnt_t       count;

  logic                 hash_valid;
  htlp_pkg::idx_t       hash_home;

  logic                 ram_we;
  htlp_pkg::idx_t       ram_waddr;
  htlp_pkg::slot_t      ram_wdata;
  htlp_pkg::idx_t       ram_raddr;
  htlp_pkg::slot_t      ram_rdata;

  logic                 accept;
  logic                 hit;
  logic                 at_empty;
  logic                 at_tomb;
  logic                 at_last;
  logic                 finish;
  logic [2:0]           status_next;
  logic [63:0]          rv_next;
  htlp_pkg::cnt_t       count_next;
  htlp_pkg::idx_t       free_idx;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  // Hash the incoming key straight off the port; the pipeline is empty here.
  htlp_hash u_hash (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .key       (cmd.key),
    .out_valid (hash_valid),
    .home      (hash_home)
  );

  htlp_ram #(
    .WIDTH ($bits(htlp_pkg::slot_t)),
    .DEPTH (htlp_pkg::CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Slot under examination in the probe state is cur_idx, read last cycle.
  assign hit      = (ram_rdata.mark == htlp_pkg::MARK_LIVE) && (ram_rdata.key == cmd_q.key);
  assign at_empty = (ram_rdata.mark == htlp_pkg::MARK_EMPTY);
  assign at_tomb  = (ram_rdata.mark == htlp_pkg::MARK_TOMB);
  assign at_last  = (step == htlp_pkg::idx_t'(htlp_pkg::CAPACITY - 1));
  // First tombstone of the walk, else the current slot.
  assign free_idx = have_tomb ? tomb_idx : cur_idx;

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cur_idx;
    ram_wdata   = '0;
    // Fetch the home slot while hashing ends, then stream the next slot.
    ram_raddr   = (state == S_HASH) ? hash_home : htlp_pkg::idx_t'(cur_idx + 1'b1);
    finish      = 1'b0;
    status_next = htlp_pkg::ST_NOT_FOUND;
    rv_next     = '0;
    count_next  = count;

    case (state)
      S_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = clr_idx;
        ram_wdata.mark = htlp_pkg::MARK_EMPTY;
      end
      S_PROBE: begin
        case (cmd_q.op)
          htlp_pkg::OP_INSERT: begin
            if (hit) begin
              // Update the value in place
              ram_we      = 1'b1;
              ram_wdata   = '{mark: htlp_pkg::MARK_LIVE, key: cmd_q.key, value: cmd_q.value};
              status_next = htlp_pkg::ST_UPDATED;
              finish      = 1'b1;
            end else if (at_empty || (at_last && (have_tomb || at_tomb))) begin
              // Fill the first tombstone passed, else this slot
              ram_we      = 1'b1;
              ram_waddr   = free_idx;
              ram_wdata   = '{mark: htlp_pkg::MARK_LIVE, key: cmd_q.key, value: cmd_q.value};
              status_next = htlp_pkg::ST_INSERTED;
              count_next  = htlp_pkg::cnt_t'(count + 1'b1);
              finish      = 1'b1;
            end else if (at_last) begin
              status_next = htlp_pkg::ST_FULL;
              finish      = 1'b1;
            end
          end
          htlp_pkg::OP_REMOVE: begin
            if (hit) begin
              // Mark as tombstone; keep key and value bits as read
              ram_we         = 1'b1;
              ram_wdata      = ram_rdata;
              ram_wdata.mark = htlp_pkg::MARK_TOMB;
              status_next    = htlp_pkg::ST_REMOVED;
              if (count != '0) begin
                count_next = htlp_pkg::cnt_t'(count - 1'b1);
              end
              finish = 1'b1;
            end else if (at_empty || at_last) begin
              finish = 1'b1;
            end
          end
          default: begin
            // Lookup, and the unused op code that acts as one
            if (hit) begin
              status_next = htlp_pkg::ST_FOUND;
              rv_next     = ram_rdata.value;
              finish      = 1'b1;
            end else if (at_empty || at_last) begin
              finish = 1'b1;
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      have_tomb <= 1'b0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= htlp_pkg::idx_t'(clr_idx + 1'b1);
          if (clr_idx == htlp_pkg::idx_t'(htlp_pkg::CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_valid) begin
            cur_idx   <= hash_home;
            step      <= '0;
            have_tomb <= 1'b0;
            state     <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (finish) begin
            state                <= S_IDLE;
            done                 <= 1'b1;
            count                <= count_next;
            result.status        <= status_next;
            result.read_value    <= rv_next;
            result.occupancy     <= htlp_pkg::occ_t'(count_next);
          end else begin
            // Advance one slot, wrapping at the end of the table
            cur_idx <= htlp_pkg::idx_t'(cur_idx + 1'b1);
            step    <= htlp_pkg::idx_t'(step + 1'b1);
            if (at_tomb && !have_tomb) begin
              have_tomb <= 1'b1;
              tomb_idx  <= cur_idx;
            end
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  `HTLP_CHECK(a_done_single, done |=> !done, "result strobe held past one cycle")
  `HTLP_CHECK(a_accept_busy, accept |=> busy, "command taken but block not busy")
  `HTLP_CHECK(a_count_cap, count <= htlp_pkg::cnt_t'(htlp_pkg::CAPACITY), "live count above capacity")
  `HTLP_CHECK(a_hash_in_hash, hash_valid |-> (state == S_HASH), "hash result outside hash wait")
  `HTLP_CHECK_ALWAYS(a_rst_quiet, rst |=> (!done && busy), "block active right after reset")

endmodule

// File: bench/hash_table_linear_probe_tb.sv
// Self-checking bench for the linear-probe hash table: directed rows, then random traffic.
module hash_table_linear_probe_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes the package leaves unnamed; the spare code decodes as a lookup.
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] ALT_5    = {16{4'h5}};
  localparam logic [63:0] ALT_A    = {16{4'hA}};

  // Stop the random tail once this many words have gone in.
  localparam int TOTAL_WORDS = 1550;

  // One directed row: a command word and, where it is obvious, the response typed in.
  typedef struct {
    htlp_pkg::cmd_t word;
    bit             typed;
    htlp_pkg::rsp_t want;
  } probe_row_t;

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  htlp_pkg::cmd_t cmd   = '0;
  logic           busy;
  logic           done;
  htlp_pkg::rsp_t result;

  // Shadow copy of the slot store, updated as each word is taken.
  logic [1:0]  shadow_mark [htlp_pkg::CAPACITY];
  logic [63:0] shadow_key  [htlp_pkg::CAPACITY];
  logic [63:0] shadow_val  [htlp_pkg::CAPACITY];
  int unsigned shadow_live;

  htlp_pkg::rsp_t pending_rsp [$];   // responses still owed by the block, oldest first
  probe_row_t     probe_rows  [$];
  logic [63:0]    key_pool    [$];   // small key set so hits, updates and removes happen
  htlp_pkg::rsp_t due_rsp;
  int             n_sent = 0;
  int             n_err  = 0;
  int             calm   = 0;        // words left in a stretch with no idle gaps

  hash_table_linear_probe DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: the slowest legal run (every word walking the whole ring after a
  // long gap) stays well under a quarter of this.
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] splitmix(input logic [63:0] x);
    logic [63:0] z;
    z = x + htlp_pkg::MIX_C0;
    z = (z ^ (z >> 30)) * htlp_pkg::MIX_C1;
    z = (z ^ (z >> 27)) * htlp_pkg::MIX_C2;
    return z ^ (z >> 31);
  endfunction

  function automatic int unsigned home_slot(input logic [63:0] key);
    logic [63:0] h;
    h = splitmix(key);
    return 32'(h[htlp_pkg::IDX_W-1:0]);
  endfunction

  // Apply one command word to the shadow table and return the response it owes.
  function automatic htlp_pkg::rsp_t hash_op_result(input htlp_pkg::cmd_t w);
    htlp_pkg::rsp_t r;
    int unsigned    home;
    int unsigned    idx;
    int unsigned    spot;
    bit             have_spot;
    bit             updated;
    int             hit;
    r         = '0;
    r.status  = htlp_pkg::ST_NOT_FOUND;
    home      = home_slot(w.key);
    spot      = 0;
    have_spot = 1'b0;
    updated   = 1'b0;
    hit       = -1;
    if (w.op == htlp_pkg::OP_INSERT) begin
      // Remember the first tombstone; an empty slot ends the walk and is used
      // only when no tombstone came before it.
      for (int i = 0; i < htlp_pkg::CAPACITY; i++) begin
        idx = (home + i) % htlp_pkg::CAPACITY;
        if (shadow_mark[idx] == htlp_pkg::MARK_EMPTY) begin
          if (!have_spot) begin
            spot      = idx;
            have_spot = 1'b1;
          end
          break;
        end
        if (shadow_mark[idx] == htlp_pkg::MARK_TOMB && !have_spot) begin
          spot      = idx;
          have_spot = 1'b1;
        end
        if (shadow_mark[idx] == htlp_pkg::MARK_LIVE && shadow_key[idx] == w.key) begin
          shadow_val[idx] = w.value;
          r.status        = htlp_pkg::ST_UPDATED;
          updated         = 1'b1;
          break;
        end
      end
      if (!updated) begin
        if (have_spot) begin
          shadow_key[spot]  = w.key;
          shadow_val[spot]  = w.value;
          shadow_mark[spot] = htlp_pkg::MARK_LIVE;
          shadow_live++;
          r.status = htlp_pkg::ST_INSERTED;
        end else begin
          r.status = htlp_pkg::ST_FULL;
        end
      end
    end else begin
      // Lookup, remove and the spare code share one walk that stops at empty.
      for (int i = 0; i < htlp_pkg::CAPACITY; i++) begin
        idx = (home + i) % htlp_pkg::CAPACITY;
        if (shadow_mark[idx] == htlp_pkg::MARK_EMPTY) break;
        if (shadow_mark[idx] == htlp_pkg::MARK_LIVE && shadow_key[idx] == w.key) begin
          hit = idx;
          break;
        end
      end
      if (hit >= 0) begin
        if (w.op == htlp_pkg::OP_REMOVE) begin
          shadow_mark[hit] = htlp_pkg::MARK_TOMB;
          if (shadow_live > 0) shadow_live--;
          r.status = htlp_pkg::ST_REMOVED;
        end else begin
          r.status     = htlp_pkg::ST_FOUND;
          r.read_value = shadow_val[hit];
        end
      end
    end
    r.occupancy = htlp_pkg::occ_t'(shadow_live);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: the block cannot stall responses, so take each one as done shows it
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("response word with nothing outstanding: status %0d", result.status);
        n_err++;
      end else begin
        due_rsp = pending_rsp.pop_front();
        if (result.status !== due_rsp.status) begin
          $error("status: expected %0d, got %0d", due_rsp.status, result.status);
          n_err++;
        end
        if (result.read_value !== due_rsp.read_value) begin
          $error("read_value: expected %h, got %h", due_rsp.read_value, result.read_value);
          n_err++;
        end
        if (result.occupancy !== due_rsp.occupancy) begin
          $error("occupancy: expected %0d, got %0d", due_rsp.occupancy, result.occupancy);
          n_err++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Mostly random, with the all-zero and all-one extremes now and then.
  function automatic logic [63:0] random_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return random_key();
  endfunction

  // Draw keys until one hashes to the given slot; about CAPACITY tries on average.
  function automatic logic [63:0] key_at_home(input int unsigned slot);
    logic [63:0] k;
    do k = random_key(); while (home_slot(k) != slot);
    return k;
  endfunction

  // Key of a random live slot; call only while the shadow table holds one.
  function automatic logic [63:0] live_key();
    int unsigned idx;
    do idx = $urandom_range(0, htlp_pkg::CAPACITY - 1);
    while (shadow_mark[idx] != htlp_pkg::MARK_LIVE);
    return shadow_key[idx];
  endfunction

  function automatic htlp_pkg::cmd_t cmd_word(input logic [1:0] op, input logic [63:0] key,
                                              input logic [63:0] value);
    htlp_pkg::cmd_t w;
    w.op    = op;
    w.key   = key;
    w.value = value;
    return w;
  endfunction

  function automatic void add_row(input logic [1:0] op, input logic [63:0] key,
                                  input logic [63:0] value, input bit typed,
                                  input logic [2:0] st, input logic [63:0] rv,
                                  input int occ);
    probe_row_t row;
    row.word            = cmd_word(op, key, value);
    row.typed           = typed;
    row.want.status     = st;
    row.want.read_value = rv;
    row.want.occupancy  = htlp_pkg::occ_t'(occ);
    probe_rows.push_back(row);
  endfunction

  // Present one word, hold it until busy is low at an edge, then book its response.
  // Call at a rising edge at which start has not been assigned yet.
  task automatic issue(input htlp_pkg::cmd_t w, input bit typed, input htlp_pkg::rsp_t want);
    htlp_pkg::rsp_t model_rsp;
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    // Always advance the shadow table, even when the response is typed in.
    model_rsp = hash_op_result(w);
    pending_rsp.push_back(typed ? want : model_rsp);
    n_sent++;
    // Idle between words: usually none, else mostly short gaps, a few long ones, and calm stretches.
    if (calm > 0) begin
      calm--;
    end else if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(20, 60);
    end else if ($urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      cmd   <= cmd_word(2'($urandom_range(0, 3)), random_key(), random_key());
      repeat (($urandom_range(0, 6) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic send(input logic [1:0] op, input logic [63:0] key,
                      input logic [63:0] value);
    issue(cmd_word(op, key, value), 1'b0, '0);
  endtask

  // Drop start and wait until every booked response has come back.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  // Random mix over the key pool, with a few live and fresh keys thrown in.
  task automatic mixed_traffic(input int n);
    int          r;
    logic [1:0]  op;
    logic [63:0] k;
    for (int j = 0; j < n; j++) begin
      r  = $urandom_range(0, 99);
      op = (r < 40) ? htlp_pkg::OP_INSERT :
           (r < 70) ? OP_LOOKUP :
           (r < 93) ? htlp_pkg::OP_REMOVE : OP_SPARE;
      r  = $urandom_range(0, 9);
      if (r < 8)                         k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else if (r == 8 && shadow_live > 0) k = live_key();
      else                               k = random_key();
      send(op, k, random_value());
    end
  endtask

  // Fill every slot, then hit the table while it is full and churn its tombstones.
  task automatic fill_table();
    int          r;
    logic [63:0] k;
    while (shadow_live < htlp_pkg::CAPACITY) begin
      r = $urandom_range(0, 9);
      if (r < 8 || shadow_live == 0) send(htlp_pkg::OP_INSERT, random_key(), random_value());
      else if (r == 8)               send(OP_LOOKUP, live_key(), random_value());
      else                           send(htlp_pkg::OP_INSERT, live_key(), random_value());
    end
    // No empty slot left: misses walk the whole ring, new keys report full,
    // and updates of present keys still land.
    repeat (6) begin
      send(htlp_pkg::OP_INSERT, random_key(), random_value());
      send(OP_LOOKUP, random_key(), random_value());
      send(htlp_pkg::OP_INSERT, live_key(), random_value());
      send(htlp_pkg::OP_REMOVE, random_key(), random_value());
    end
    // Open one tombstone at a time and refill it with a fresh key.
    repeat (10) begin
      k = live_key();
      send(htlp_pkg::OP_REMOVE, k, random_value());
      send(OP_LOOKUP, k, random_value());
      send(htlp_pkg::OP_INSERT, random_key(), random_value());
      send(htlp_pkg::OP_INSERT, random_key(), random_value());
      send(OP_SPARE, live_key(), random_value());
    end
  endtask

  // Remove every live key in random order, leaving a ring of tombstones.
  task automatic drain_table();
    logic [63:0] live_keys [$];
    int          j;
    foreach (shadow_mark[i])
      if (shadow_mark[i] == htlp_pkg::MARK_LIVE) live_keys.push_back(shadow_key[i]);
    while (live_keys.size() > 0) begin
      j = $urandom_range(0, live_keys.size() - 1);
      send(htlp_pkg::OP_REMOVE, live_keys[j], random_value());
      if ($urandom_range(0, 6) == 0) send(OP_LOOKUP, live_keys[j], random_value());
      live_keys.delete(j);
    end
    // Every slot is a tombstone: misses walk all slots without meeting an empty one.
    repeat (4) begin
      send(OP_LOOKUP, random_key(), random_value());
      send(htlp_pkg::OP_REMOVE, random_key(), random_value());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic [63:0] chain [4];
    logic [63:0] next_door;
    int unsigned h1;

    foreach (shadow_mark[i]) begin
      shadow_mark[i] = htlp_pkg::MARK_EMPTY;
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
    end
    shadow_live = 0;

    // Keys for probe chains: four sharing the last slot so the chain wraps to
    // slot zero, and one whose home is slot zero to collide with the wrap.
    foreach (chain[i]) chain[i] = key_at_home(htlp_pkg::CAPACITY - 1);
    next_door = key_at_home(0);

    // Pool: both extremes, random keys, and clusters at a random home, its
    // neighbor, and the last slot.
    h1 = $urandom_range(0, htlp_pkg::CAPACITY - 3);
    key_pool.push_back('0);
    key_pool.push_back(ALL_ONES);
    repeat (22) key_pool.push_back(random_key());
    repeat (8) begin
      key_pool.push_back(key_at_home(h1));
      key_pool.push_back(key_at_home(h1 + 1));
      key_pool.push_back(key_at_home(htlp_pkg::CAPACITY - 1));
    end

    //      op                   key       value     typed status                 read_value occ
    add_row(OP_LOOKUP,           '0,       '0,       1'b1, htlp_pkg::ST_NOT_FOUND, '0,       0);
    add_row(htlp_pkg::OP_REMOVE, ALL_ONES, '0,       1'b1, htlp_pkg::ST_NOT_FOUND, '0,       0);
    add_row(htlp_pkg::OP_INSERT, '0,       ALL_ONES, 1'b1, htlp_pkg::ST_INSERTED,  '0,       1);
    add_row(OP_LOOKUP,           '0,       ALT_A,    1'b1, htlp_pkg::ST_FOUND,     ALL_ONES, 1);
    add_row(htlp_pkg::OP_INSERT, '0,       '0,       1'b1, htlp_pkg::ST_UPDATED,   '0,       1);
    add_row(OP_SPARE,            '0,       ALL_ONES, 1'b1, htlp_pkg::ST_FOUND,     '0,       1);
    add_row(htlp_pkg::OP_INSERT, ALL_ONES, ALT_5,    1'b1, htlp_pkg::ST_INSERTED,  '0,       2);
    add_row(OP_LOOKUP,           ALL_ONES, '0,       1'b1, htlp_pkg::ST_FOUND,     ALT_5,    2);
    add_row(htlp_pkg::OP_REMOVE, '0,       ALL_ONES, 1'b1, htlp_pkg::ST_REMOVED,   '0,       1);
    add_row(OP_LOOKUP,           '0,       '0,       1'b1, htlp_pkg::ST_NOT_FOUND, '0,       1);
    add_row(htlp_pkg::OP_REMOVE, '0,       '0,       1'b1, htlp_pkg::ST_NOT_FOUND, '0,       1);
    add_row(htlp_pkg::OP_INSERT, '0,       ALT_A,    1'b1, htlp_pkg::ST_INSERTED,  '0,       2);
    add_row(OP_LOOKUP,           '0,       '0,       1'b1, htlp_pkg::ST_FOUND,     ALT_A,    2);
    // Collision chain across the wrap, a tombstone in its middle, an update past
    // the tombstone, and a fresh key that must reuse it.
    add_row(htlp_pkg::OP_INSERT, chain[0],  ALT_A,    1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(htlp_pkg::OP_INSERT, chain[1],  ALT_5,    1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(htlp_pkg::OP_INSERT, chain[2],  ALL_ONES, 1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(htlp_pkg::OP_INSERT, next_door, 64'd1,    1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(htlp_pkg::OP_REMOVE, chain[1],  '0,       1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(OP_LOOKUP,           chain[2],  '0,       1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(htlp_pkg::OP_INSERT, chain[2],  64'd7,    1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(htlp_pkg::OP_INSERT, chain[3],  64'd2,    1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(OP_LOOKUP,           chain[3],  '0,       1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(OP_SPARE,            chain[1],  '0,       1'b0, htlp_pkg::ST_FOUND, '0, 0);
    add_row(OP_LOOKUP,           next_door, '0,       1'b0, htlp_pkg::ST_FOUND, '0, 0);

    // Hold reset, then release it; the clearing pass then shows up as busy.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i]) issue(probe_rows[i].word, probe_rows[i].typed, probe_rows[i].want);
    hold_until_drained();

    mixed_traffic(650);
    hold_until_drained();

    fill_table();
    hold_until_drained();

    drain_table();
    if (n_sent < TOTAL_WORDS) mixed_traffic(TOTAL_WORDS - n_sent);

    // Let the last walk finish, then watch a little longer for stray responses.
    hold_until_drained();
    repeat (20) @(posedge clk);

    if (n_err == 0 && pending_rsp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
